FILE: hdl/lftp_pkg.sv
// ----------------------------------------------------------------------------
// lftp_pkg
// Types and constants shared by the LSB-first tagged field parser.
// ----------------------------------------------------------------------------
package lftp_pkg;

    localparam int unsigned TAG_W      = 9;
    localparam int unsigned SHIFT_W    = 40;
    localparam int unsigned HELD_W     = 6;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned ID_W       = 4;

    localparam logic [POS_W-1:0] RESET_BIT_LIMIT = 16'd432;   // 54 bytes

    // end_cause codes
    localparam logic [1:0] CAUSE_UNKNOWN_TAG = 2'd0;
    localparam logic [1:0] CAUSE_BIT_LIMIT   = 2'd1;
    localparam logic [1:0] CAUSE_TRUNCATED   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic               has_stat;
        logic [ID_W-1:0]    stat_id;
        logic [VALUE_W-1:0] stat_value;
        logic               finished;
        logic [1:0]         end_cause;
    } out_t;

    // Record state; bits of shift above held are always zero.
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [HELD_W-1:0]  held;
        logic               reading;
        logic [ID_W-1:0]    tag;
        logic [POS_W-1:0]   pos;
        logic               done;
    } state_t;

    localparam state_t STATE_CLEAR = '0;

    function automatic logic [HELD_W-1:0] value_width(input logic [ID_W-1:0] id);
        logic [HELD_W-1:0] w;
        priority if (id <= 4'd4)  w = 6'd10;
        else if (id == 4'd5)      w = 6'd8;
        else if (id <= 4'd11)     w = 6'd21;
        else if (id == 4'd12)     w = 6'd7;
        else if (id == 4'd13)     w = 6'd32;
        else                      w = 6'd25;
        return w;
    endfunction

    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] pos,
                                                 input logic [HELD_W-1:0] w);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + {{(POS_W+1-HELD_W){1'b0}}, w};
        return sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
    endfunction

endpackage

FILE: hdl/lftp_in_stage.sv
// ----------------------------------------------------------------------------
// lftp_in_stage
// Input register: holds one accepted byte until the parse step takes it.
// ----------------------------------------------------------------------------
module lftp_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lftp_pkg::in_t  in_data,
    output logic           hold_valid,
    output lftp_pkg::in_t  hold_data,
    input  logic           take
);

    logic          valid_reg;
    logic          valid_next;
    lftp_pkg::in_t data_reg;

    assign in_ready   = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: hdl/lftp_step.sv
// ----------------------------------------------------------------------------
// lftp_step
// Parse step for one byte: at most one tag and one value are taken.
// ----------------------------------------------------------------------------
module lftp_step (
    input  lftp_pkg::state_t             cur,
    input  lftp_pkg::in_t                item,
    input  logic [lftp_pkg::POS_W-1:0]   bit_limit,
    output lftp_pkg::state_t             nxt,
    output lftp_pkg::out_t               res,
    output logic                         produce
);

    logic [lftp_pkg::SHIFT_W-1:0] sh1;
    logic [lftp_pkg::SHIFT_W-1:0] sh2;
    logic [lftp_pkg::HELD_W-1:0]  h1;
    logic [lftp_pkg::HELD_W-1:0]  h2;
    logic [lftp_pkg::POS_W-1:0]   pos2;
    logic [lftp_pkg::POS_W-1:0]   pos3;
    logic                         reading1;
    logic [lftp_pkg::ID_W-1:0]    tag1;
    logic [lftp_pkg::TAG_W-1:0]   raw_tag;
    logic [lftp_pkg::HELD_W-1:0]  w;
    logic [lftp_pkg::VALUE_W-1:0] mask;
    logic [lftp_pkg::VALUE_W-1:0] val;
    logic                         has;
    logic                         fin;
    logic [1:0]                   cause;

    always_comb
    begin
        nxt      = cur;
        res      = '0;
        produce  = 1'b0;
        has      = 1'b0;
        fin      = 1'b0;
        cause    = lftp_pkg::CAUSE_UNKNOWN_TAG;
        val      = '0;
        sh1      = cur.shift | ({{(lftp_pkg::SHIFT_W-8){1'b0}}, item.data_byte} << cur.held);
        h1       = cur.held + 6'd8;
        sh2      = sh1;
        h2       = h1;
        pos2     = cur.pos;
        pos3     = cur.pos;
        reading1 = cur.reading;
        tag1     = cur.tag;
        raw_tag  = sh1[lftp_pkg::TAG_W-1:0];

        // tag
        if (!cur.reading)
        begin
            if (cur.pos >= bit_limit)
            begin
                fin   = 1'b1;
                cause = lftp_pkg::CAUSE_BIT_LIMIT;
            end
            else if (h1 >= 6'(lftp_pkg::TAG_W))
            begin
                sh2  = sh1 >> lftp_pkg::TAG_W;
                h2   = h1 - 6'(lftp_pkg::TAG_W);
                pos2 = lftp_pkg::pos_add(cur.pos, 6'(lftp_pkg::TAG_W));
                if (raw_tag[lftp_pkg::TAG_W-1:lftp_pkg::ID_W] != '0)
                begin
                    fin   = 1'b1;
                    cause = lftp_pkg::CAUSE_UNKNOWN_TAG;
                end
                else
                begin
                    tag1     = raw_tag[lftp_pkg::ID_W-1:0];
                    reading1 = 1'b1;
                end
            end
        end

        // value
        w    = lftp_pkg::value_width(tag1);
        mask = {lftp_pkg::VALUE_W{1'b1}} >> (6'd32 - w);
        pos3 = pos2;
        nxt.shift   = sh2;
        nxt.held    = h2;
        nxt.reading = reading1;
        nxt.tag     = tag1;
        nxt.pos     = pos2;
        if (!fin && reading1 && (h2 >= w))
        begin
            val = sh2[lftp_pkg::VALUE_W-1:0] & mask;
            if (tag1 >= 4'd6 && tag1 <= 4'd11)
            begin
                val = val >> 8;
            end
            has         = 1'b1;
            pos3        = lftp_pkg::pos_add(pos2, w);
            nxt.shift   = sh2 >> w;
            nxt.held    = h2 - w;
            nxt.reading = 1'b0;
            nxt.pos     = pos3;
            if (pos3 >= bit_limit)
            begin
                fin   = 1'b1;
                cause = lftp_pkg::CAUSE_BIT_LIMIT;
            end
        end

        if (!fin && item.is_last)
        begin
            fin   = 1'b1;
            cause = lftp_pkg::CAUSE_TRUNCATED;
        end

        if (fin)
        begin
            nxt.done = 1'b1;
        end

        res.has_stat   = has;
        res.stat_id    = has ? tag1 : '0;
        res.stat_value = val;
        res.finished   = fin;
        res.end_cause  = fin ? cause : lftp_pkg::CAUSE_UNKNOWN_TAG;
        produce        = has || fin;

        // after the end, bytes are dropped until is_last
        if (cur.done)
        begin
            nxt     = cur;
            res     = '0;
            produce = 1'b0;
        end
        if ((cur.done || fin) && item.is_last)
        begin
            nxt = lftp_pkg::STATE_CLEAR;
        end
    end

endmodule

FILE: hdl/lsb_first_tagged_field_parser.sv
// ----------------------------------------------------------------------------
// lsb_first_tagged_field_parser
// Reads 9-bit tags and tag-sized values LSB first from a byte stream and
// reports each tag/value pair and the end of each record.
//
//   port group         dir   handshake          payload
//   in_*               in    in_valid/in_ready  lftp_pkg::in_t
//   out_*              out   out_valid/out_ready lftp_pkg::out_t
//   cfg_*              in    cfg_wr_en          bit_limit (16 bits)
//
// One byte per cycle sustained unless a byte with a result meets a stalled
// output. A byte goes from the input register to the result register; the
// record state loop (shift buffer, bit count, position) closes in lftp_step.
// Reset clears record state and loads bit_limit with 432.
// A stalled result holds the parse stage only when that byte yields a result;
// bytes that give none still pass.
// ----------------------------------------------------------------------------
module lsb_first_tagged_field_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lftp_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lftp_pkg::out_t              out_data,
    input  logic                        cfg_wr_en,
    input  logic [lftp_pkg::POS_W-1:0]  cfg_wr_data
);

    logic                       hold_valid;
    lftp_pkg::in_t              hold_data;
    logic                       take;
    lftp_pkg::state_t           state_reg;
    lftp_pkg::state_t           state_next;
    lftp_pkg::out_t             res;
    logic                       produce;
    logic [lftp_pkg::POS_W-1:0] bit_limit_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    lftp_pkg::out_t             out_data_reg;

    lftp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .hold_valid (hold_valid),
        .hold_data  (hold_data),
        .take       (take)
    );

    lftp_step u_step (
        .cur       (state_reg),
        .item      (hold_data),
        .bit_limit (bit_limit_reg),
        .nxt       (state_next),
        .res       (res),
        .produce   (produce)
    );

    assign take = hold_valid && (!produce || !out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lftp_pkg::STATE_CLEAR;
            bit_limit_reg <= lftp_pkg::RESET_BIT_LIMIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (cfg_wr_en)
            begin
                bit_limit_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && produce)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
